// ----- src/x_drive_wheel_mixer_core_assert.svh -----
// Assertion macros for the X-drive wheel mixer core.
// Included by x_drive_wheel_mixer_core, which checks its own pipeline; needs nothing else.
`ifndef X_DRIVE_WHEEL_MIXER_CORE_ASSERT_SVH
`define X_DRIVE_WHEEL_MIXER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property outside reset.
`define XDW_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("xdw assertion failed");
// Check a property at every edge, reset included.
`define XDW_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("xdw assertion failed");
`else
`define XDW_ASSERT(name, clk, rst_n, prop)
`define XDW_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// ----- src/xdw_pkg.sv -----
// Types and constants shared by the X-drive wheel mixer files.
// No dependencies.
`default_nettype none

package xdw_pkg;

  localparam int unsigned ANGLE_BITS  = 16;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned FRAC_BITS   = SAMPLE_BITS - 1;

  // octant angle, 0 .. pi/4 inclusive
  localparam int unsigned U_W    = ANGLE_BITS - 2;
  localparam int unsigned TRIG_W = 31;

  localparam logic [TRIG_W-1:0]   ONE_Q30   = 31'h4000_0000;
  localparam logic [31:0]         PI_Q30    = 32'd3373259426;
  localparam logic [U_W-1:0]      OCT_SIZE  = {1'b1, {(ANGLE_BITS-3){1'b0}}};
  localparam logic [ANGLE_BITS-2:0] QUAD_SIZE = {1'b1, {(ANGLE_BITS-2){1'b0}}};

  // Horner terms; divisions by the term constants use rounded-up reciprocals
  localparam int unsigned COS_TERMS = 5;
  localparam int unsigned SIN_TERMS = 4;

  localparam int unsigned COS_SH [COS_TERMS] = '{37, 36, 35, 34, 31};
  localparam logic [30:0] COS_RCP [COS_TERMS] = '{
    31'((64'd1 << 37) / 90 + 1),
    31'((64'd1 << 36) / 56 + 1),
    31'((64'd1 << 35) / 30 + 1),
    31'((64'd1 << 34) / 12 + 1),
    31'((64'd1 << 31) / 2 + 1)
  };

  localparam int unsigned SIN_SH [SIN_TERMS] = '{37, 36, 35, 33};
  localparam logic [30:0] SIN_RCP [SIN_TERMS] = '{
    31'((64'd1 << 37) / 72 + 1),
    31'((64'd1 << 36) / 42 + 1),
    31'((64'd1 << 35) / 20 + 1),
    31'((64'd1 << 33) / 6 + 1)
  };

  typedef struct packed {
    logic [SAMPLE_BITS-1:0]        magnitude;
    logic [ANGLE_BITS-1:0]         heading;
    logic signed [SAMPLE_BITS-1:0] spin;
  } cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] wheel_a;
    logic signed [SAMPLE_BITS-1:0] wheel_b;
    logic signed [SAMPLE_BITS-1:0] wheel_c;
    logic signed [SAMPLE_BITS-1:0] wheel_d;
  } wheels_t;

endpackage

`default_nettype wire

// ----- src/xdw_octant.sv -----
// Pipelined sine and cosine of an angle in 0 .. pi/4, Q30 unsigned.
// Uses xdw_pkg; takes one angle per cycle.
`default_nettype none

module xdw_octant
  import xdw_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic [U_W-1:0]    u_i,
  output logic      [TRIG_W-1:0] sin_o,
  output logic      [TRIG_W-1:0] cos_o
);

  localparam int unsigned CARRY = 2 * SIN_TERMS;

  logic [U_W+31:0] xp;
  logic [59:0]     xx;
  logic [29:0]     x1_q, x2_q, xd_q;
  logic [29:0]     x2c_q [CARRY];
  logic [29:0]     xc_q  [CARRY];
  logic [29:0]     qp_q  [COS_TERMS];
  logic [30:0]     qv_q  [COS_TERMS];
  logic [29:0]     pp_q  [SIN_TERMS];
  logic [30:0]     pv_q  [SIN_TERMS];
  logic [60:0]     sp;
  logic [29:0]     sp_q, so_q;

  assign xp = (U_W+32)'(u_i) * (U_W+32)'(PI_Q30);
  assign xx = 60'(x1_q) * 60'(x1_q);

  always_ff @(posedge clk_i) begin
    x1_q <= xp[ANGLE_BITS-1 +: 30];
    x2_q <= xx[59:30];
    xd_q <= x1_q;
    x2c_q[0] <= x2_q;
    xc_q[0]  <= xd_q;
    for (int i = 1; i < CARRY; i++) begin
      x2c_q[i] <= x2c_q[i-1];
      xc_q[i]  <= xc_q[i-1];
    end
  end

  // cosine: one multiply stage and one constant-divide stage per term
  for (genvar k = 0; k < COS_TERMS; k++) begin : g_cos
    logic [29:0] x2_in;
    logic [30:0] q_in;
    logic [60:0] prod, quo;
    if (k == 0) begin : g_first
      assign x2_in = x2_q;
      assign q_in  = ONE_Q30;
    end else begin : g_next
      assign x2_in = x2c_q[2*k-1];
      assign q_in  = qv_q[k-1];
    end
    assign prod = 61'(x2_in) * 61'(q_in);
    assign quo  = 61'(qp_q[k]) * 61'(COS_RCP[k]);
    always_ff @(posedge clk_i) begin
      qp_q[k] <= prod[59:30];
      qv_q[k] <= ONE_Q30 - 31'(quo >> COS_SH[k]);
    end
  end

  for (genvar k = 0; k < SIN_TERMS; k++) begin : g_sin
    logic [29:0] x2_in;
    logic [30:0] p_in;
    logic [60:0] prod, quo;
    if (k == 0) begin : g_first
      assign x2_in = x2_q;
      assign p_in  = ONE_Q30;
    end else begin : g_next
      assign x2_in = x2c_q[2*k-1];
      assign p_in  = pv_q[k-1];
    end
    assign prod = 61'(x2_in) * 61'(p_in);
    assign quo  = 61'(pp_q[k]) * 61'(SIN_RCP[k]);
    always_ff @(posedge clk_i) begin
      pp_q[k] <= prod[59:30];
      pv_q[k] <= ONE_Q30 - 31'(quo >> SIN_SH[k]);
    end
  end

  assign sp = 61'(xc_q[CARRY-1]) * 61'(pv_q[SIN_TERMS-1]);

  // hold sine one extra stage to line up with the longer cosine chain
  always_ff @(posedge clk_i) begin
    sp_q <= sp[59:30];
    so_q <= sp_q;
  end

  assign sin_o = {1'b0, so_q};
  assign cos_o = qv_q[COS_TERMS-1];

endmodule

`default_nettype wire

// ----- src/x_drive_wheel_mixer_core.sv -----
// Top level of the X-drive wheel mixer: command in, four wheel values out.
// Uses xdw_pkg, xdw_octant and x_drive_wheel_mixer_core_assert.svh.
`default_nettype none

// Takes one drive command per clock and returns the four wheel values for each
// command taken; busy never rises, so a command may be given in every cycle.
// Each result shows on wheels_o for exactly one cycle with done_o high and must
// be taken then. The pipeline runs through the Horner chain of the trig unit
// (12 stages), a 32-stage restoring divider for the stretched terms and a
// 16-stage restoring divider for normalization.
module x_drive_wheel_mixer_core
  import xdw_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire cmd_t cmd_i,
  output logic      done_o,
  output wheels_t   wheels_o
);

`include "x_drive_wheel_mixer_core_assert.svh"

  localparam int unsigned OCT_LAT = 2 + 2 * COS_TERMS;
  localparam int unsigned QA_W    = 32;
  localparam int unsigned D1_N    = QA_W;
  localparam int unsigned D2_N    = FRAC_BITS + 1;
  localparam int unsigned SHIFT   = 30 - FRAC_BITS;
  localparam int unsigned W_W     = 35;
  localparam int unsigned A_W     = W_W - 1;
  localparam int unsigned I_M     = OCT_LAT + 1;
  localparam int unsigned I_D1    = I_M + 1 + D1_N;
  localparam int unsigned I_D2    = I_D1 + 3;
  localparam int unsigned LAT     = I_D2 + D2_N + 2;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic [FRAC_BITS:0] PEAK = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {FRAC_BITS{1'b1}}};

  typedef struct packed {
    logic [SAMPLE_BITS-1:0]        mag;
    logic signed [SAMPLE_BITS-1:0] spin;
    logic [1:0]                    quad;
    logic                          swap;
  } side_t;

  typedef struct packed {
    logic signed [63:0]        pa;
    logic signed [63:0]        pb;
    logic [TRIG_W-1:0]         ct;
    logic signed [31:0]        spq;
  } mstage_t;

  typedef struct packed {
    logic [TRIG_W-1:0] rem;
    logic [QA_W-1:0]   lq;
  } qa_lane_t;

  typedef struct packed {
    qa_lane_t           la;
    qa_lane_t           lb;
    logic [TRIG_W-1:0]  den;
    logic               neg_a;
    logic               neg_b;
    logic signed [31:0] spq;
  } d1_t;

  typedef struct packed {
    logic [A_W-1:0]    rem;
    logic [FRAC_BITS:0] lq;
  } n_lane_t;

  typedef struct packed {
    n_lane_t [3:0]            ln;
    logic [A_W-1:0]           den;
    logic [3:0]               neg;
    logic [3:0][FRAC_BITS:0]  un;
    logic                     norm;
  } d2_t;

  function automatic qa_lane_t d1_step(qa_lane_t ln, logic [TRIG_W-1:0] den);
    logic [TRIG_W:0] trial;
    logic            ge;
    qa_lane_t        nx;
    trial  = {ln.rem, ln.lq[QA_W-1]};
    ge     = trial >= {1'b0, den};
    nx.rem = ge ? TRIG_W'(trial - {1'b0, den}) : trial[TRIG_W-1:0];
    nx.lq  = {ln.lq[QA_W-2:0], ge};
    return nx;
  endfunction

  function automatic d1_t d1_adv(d1_t s);
    d1_t n;
    n    = s;
    n.la = d1_step(s.la, s.den);
    n.lb = d1_step(s.lb, s.den);
    return n;
  endfunction

  function automatic n_lane_t d2_step(n_lane_t ln, logic [A_W-1:0] den);
    logic [A_W:0] trial;
    logic         ge;
    n_lane_t      nx;
    trial  = {ln.rem, ln.lq[FRAC_BITS]};
    ge     = trial >= {1'b0, den};
    nx.rem = ge ? A_W'(trial - {1'b0, den}) : trial[A_W-1:0];
    nx.lq  = {ln.lq[FRAC_BITS-1:0], ge};
    return nx;
  endfunction

  function automatic d2_t d2_adv(d2_t s);
    d2_t n;
    n = s;
    for (int i = 0; i < 4; i++) begin
      n.ln[i] = d2_step(s.ln[i], s.den);
    end
    return n;
  endfunction

  logic [LAT-1:0] vld_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start & ~busy};
    end
  end

  // ---- stage 0: fold the heading ----
  logic [ANGLE_BITS-4:0] oct_r;
  logic [ANGLE_BITS-1:0] aw;
  logic [U_W-1:0]        wq;
  logic [U_W-1:0]        uth_d, uw_d, uth_q, uw_q;
  side_t                 side_d, side0_q;
  side_t                 side_q [OCT_LAT];

  always_comb begin
    oct_r       = cmd_i.heading[ANGLE_BITS-4:0];
    uth_d       = cmd_i.heading[ANGLE_BITS-3] ? U_W'(oct_r) : OCT_SIZE - U_W'(oct_r);
    aw          = cmd_i.heading - ANGLE_BITS'(OCT_SIZE);
    wq          = aw[ANGLE_BITS-3:0];
    side_d.mag  = cmd_i.magnitude;
    side_d.spin = cmd_i.spin;
    side_d.quad = aw[ANGLE_BITS-1 -: 2];
    side_d.swap = wq > OCT_SIZE;
    uw_d        = side_d.swap ? U_W'(QUAD_SIZE - (ANGLE_BITS-1)'(wq)) : wq;
  end

  always_ff @(posedge clk_i) begin
    uth_q     <= uth_d;
    uw_q      <= uw_d;
    side0_q   <= side_d;
    side_q[0] <= side0_q;
    for (int i = 1; i < OCT_LAT; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  logic [TRIG_W-1:0] th_cos, w_sin, w_cos;

  xdw_octant u_oct_th (
    .clk_i (clk_i),
    .u_i   (uth_q),
    .sin_o (),
    .cos_o (th_cos)
  );

  xdw_octant u_oct_w (
    .clk_i (clk_i),
    .u_i   (uw_q),
    .sin_o (w_sin),
    .cos_o (w_cos)
  );

  // ---- stage M: quadrant map and stretch products ----
  side_t              sd;
  logic [TRIG_W-1:0]  s0, c0;
  logic signed [31:0] s0s, c0s, sn, cs, ms;
  mstage_t            m_d, m_q;

  always_comb begin
    sd  = side_q[OCT_LAT-1];
    s0  = sd.swap ? w_cos : w_sin;
    c0  = sd.swap ? w_sin : w_cos;
    s0s = signed'({1'b0, s0});
    c0s = signed'({1'b0, c0});
    case (sd.quad)
      QUAD_0: begin sn = s0s;  cs = c0s;  end
      QUAD_1: begin sn = c0s;  cs = -s0s; end
      QUAD_2: begin sn = -s0s; cs = -c0s; end
      QUAD_3: begin sn = -c0s; cs = s0s;  end
      default: begin sn = s0s; cs = c0s;  end
    endcase
    ms      = signed'(32'(sd.mag) << SHIFT);
    m_d.pa  = 64'(ms) * 64'(cs);
    m_d.pb  = 64'(ms) * 64'(sn);
    m_d.ct  = th_cos;
    m_d.spq = 32'(sd.spin) <<< SHIFT;
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d;
  end

  // ---- stage S: sign and magnitude into the first divider ----
  logic [63:0] mag_a, mag_b;
  d1_t         d1_q [D1_N+1];
  d1_t         d1_d;

  always_comb begin
    mag_a          = m_q.pa[63] ? 64'(-m_q.pa) : 64'(m_q.pa);
    mag_b          = m_q.pb[63] ? 64'(-m_q.pb) : 64'(m_q.pb);
    d1_d.la.rem    = {1'b0, mag_a[61:32]};
    d1_d.la.lq     = mag_a[31:0];
    d1_d.lb.rem    = {1'b0, mag_b[61:32]};
    d1_d.lb.lq     = mag_b[31:0];
    d1_d.den       = m_q.ct;
    d1_d.neg_a     = m_q.pa[63];
    // wheel B takes the negated quotient
    d1_d.neg_b     = ~m_q.pb[63];
    d1_d.spq       = m_q.spq;
  end

  always_ff @(posedge clk_i) begin
    d1_q[0] <= d1_d;
  end

  for (genvar k = 0; k < D1_N; k++) begin : g_div1
    always_ff @(posedge clk_i) begin
      d1_q[k+1] <= d1_adv(d1_q[k]);
    end
  end

  // ---- stage W: add spin ----
  d1_t                d1e;
  logic signed [32:0] qa_s, qb_s, an, bn;
  logic signed [W_W-1:0] w_d [4];
  logic signed [W_W-1:0] w_q [4];

  always_comb begin
    d1e    = d1_q[D1_N];
    qa_s   = signed'({1'b0, d1e.la.lq});
    qb_s   = signed'({1'b0, d1e.lb.lq});
    an     = d1e.neg_a ? -qa_s : qa_s;
    bn     = d1e.neg_b ? -qb_s : qb_s;
    w_d[0] = W_W'(an) + W_W'(d1e.spq);
    w_d[1] = W_W'(bn) + W_W'(d1e.spq);
    w_d[2] = W_W'(d1e.spq) - W_W'(an);
    w_d[3] = W_W'(d1e.spq) - W_W'(bn);
  end

  // ---- stage A: absolute values ----
  logic [A_W-1:0] abs_q [4];
  logic [3:0]     neg_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      w_q[i]   <= w_d[i];
      abs_q[i] <= w_q[i][W_W-1] ? A_W'(-w_q[i]) : A_W'(w_q[i]);
      neg_q[i] <= w_q[i][W_W-1];
    end
  end

  // ---- stage X: peak and setup of the normalizing divider ----
  logic [A_W-1:0] m01, m23, mx;
  d2_t            d2_d;
  d2_t            d2_q [D2_N+1];

  always_comb begin
    m01 = (abs_q[0] > abs_q[1]) ? abs_q[0] : abs_q[1];
    m23 = (abs_q[2] > abs_q[3]) ? abs_q[2] : abs_q[3];
    mx  = (m01 > m23) ? m01 : m23;
    d2_d.den  = mx;
    d2_d.neg  = neg_q;
    d2_d.norm = mx > A_W'(ONE_Q30);
    for (int i = 0; i < 4; i++) begin
      d2_d.ln[i].rem = A_W'(abs_q[i] >> 1);
      d2_d.ln[i].lq  = {abs_q[i][0], {FRAC_BITS{1'b0}}};
      d2_d.un[i]     = abs_q[i][SHIFT +: FRAC_BITS+1];
    end
  end

  always_ff @(posedge clk_i) begin
    d2_q[0] <= d2_d;
  end

  for (genvar k = 0; k < D2_N; k++) begin : g_div2
    always_ff @(posedge clk_i) begin
      d2_q[k+1] <= d2_adv(d2_q[k]);
    end
  end

  // ---- output stage: sign, saturate ----
  d2_t                           d2e;
  logic [FRAC_BITS:0]            mg;
  logic signed [SAMPLE_BITS-1:0] val [4];
  wheels_t                       wheels_d, wheels_q;

  always_comb begin
    d2e = d2_q[D2_N];
    mg  = '0;
    for (int i = 0; i < 4; i++) begin
      mg = d2e.norm ? d2e.ln[i].lq : d2e.un[i];
      if (d2e.neg[i]) begin
        val[i] = SAMPLE_BITS'(-{1'b0, mg});
      end else if (mg[FRAC_BITS]) begin
        val[i] = OUT_MAX;
      end else begin
        val[i] = signed'(mg);
      end
    end
    wheels_d.wheel_a = val[0];
    wheels_d.wheel_b = val[1];
    wheels_d.wheel_c = val[2];
    wheels_d.wheel_d = val[3];
  end

  always_ff @(posedge clk_i) begin
    wheels_q <= wheels_d;
  end

  assign done_o   = vld_q[LAT-1];
  assign wheels_o = wheels_q;

  `XDW_ASSERT_ALWAYS(a_quiet_in_reset, clk_i, !rst_ni |-> !done_o)
  `XDW_ASSERT(a_done_follows, clk_i, rst_ni, start |-> ##LAT done_o)
  `XDW_ASSERT(a_done_has_cause, clk_i, rst_ni, done_o |-> $past(start, LAT))
  `XDW_ASSERT(a_rem_bound, clk_i, rst_ni, vld_q[I_D1] |-> (d1e.la.rem < d1e.den) && (d1e.lb.rem < d1e.den))
  `XDW_ASSERT(a_norm_peak, clk_i, rst_ni, vld_q[I_D2+D2_N] && d2e.norm |-> (d2e.ln[0].lq == PEAK) || (d2e.ln[1].lq == PEAK) || (d2e.ln[2].lq == PEAK) || (d2e.ln[3].lq == PEAK))

endmodule

`default_nettype wire

// ----- test/x_drive_wheel_mixer_core_tb.sv -----
// Testbench for x_drive_wheel_mixer_core: drive commands in, four wheel values out.
// Depends on xdw_pkg and the core RTL. Results are checked against a fixed-point
// mixer model held here, one expected wheel set per accepted transaction.
`timescale 1ns / 100ps

module x_drive_wheel_mixer_core_tb;
  import xdw_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] PI_FIX = 64'd3373259426;
  localparam logic [63:0] OCT = 64'd1 << (ANGLE_BITS - 3);
  localparam logic [63:0] QUAD = 64'd1 << (ANGLE_BITS - 2);
  localparam logic [63:0] ANG_MASK = (64'd1 << ANGLE_BITS) - 1;
  localparam longint OUT_HI = (longint'(1) <<< FRAC_BITS) - 1;
  localparam longint OUT_LO = -(longint'(1) <<< FRAC_BITS);
  localparam longint UPSCALE = longint'(1) <<< (30 - FRAC_BITS);

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  cmd_t    cmd_i = '0;
  logic    done_o;
  wheels_t wheels_o;

  wheels_t wheels_due[$];
  int unsigned n_errors = 0;
  int unsigned cycle_cnt = 0;
  int unsigned idle_pct = 0;

  x_drive_wheel_mixer_core DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .cmd_i(cmd_i),
    .done_o(done_o),
    .wheels_o(wheels_o)
  );

  always #6 clk_i = ~clk_i;

  // sin and cos in Q30 of an angle u with 0 <= u <= pi/4
  task automatic octant_sincos(input logic [63:0] u, output longint s, output longint c);
    logic [63:0] x, x2, p, q;
    x = (u * PI_FIX) >> (ANGLE_BITS - 1);
    x2 = (x * x) >> 30;
    p = Q30_ONE;
    p = Q30_ONE - ((x2 * p) >> 30) / 72;
    p = Q30_ONE - ((x2 * p) >> 30) / 42;
    p = Q30_ONE - ((x2 * p) >> 30) / 20;
    p = Q30_ONE - ((x2 * p) >> 30) / 6;
    s = longint'((x * p) >> 30);
    q = Q30_ONE;
    q = Q30_ONE - ((x2 * q) >> 30) / 90;
    q = Q30_ONE - ((x2 * q) >> 30) / 56;
    q = Q30_ONE - ((x2 * q) >> 30) / 30;
    q = Q30_ONE - ((x2 * q) >> 30) / 12;
    q = Q30_ONE - ((x2 * q) >> 30) / 2;
    c = longint'(q);
  endtask

  task automatic circle_sincos(input logic [63:0] ang, output longint s, output longint c);
    logic [63:0] w;
    logic [1:0] quad;
    longint s0, c0;
    ang = ang & ANG_MASK;
    quad = ang[ANGLE_BITS-1 -: 2];
    w = ang & (QUAD - 1);
    if (w <= OCT) octant_sincos(w, s0, c0);
    else octant_sincos(QUAD - w, c0, s0);
    case (quad)
      2'd0: begin s = s0; c = c0; end
      2'd1: begin s = c0; c = -s0; end
      2'd2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
  endtask

  task automatic predict_wheels(input cmd_t cmd, output wheels_t res);
    logic [63:0] hd, r, th;
    longint st, ct, sn, cs, ms, a, b, spq, m, av, v;
    longint w[4];
    logic [SAMPLE_BITS-1:0] o[4];
    hd = 64'(cmd.heading);
    r = hd & (OCT - 1);
    th = hd[ANGLE_BITS-3] ? r : OCT - r;
    octant_sincos(th, st, ct);
    circle_sincos(hd + (64'd1 << ANGLE_BITS) - OCT, sn, cs);
    ms = longint'(64'(cmd.magnitude) << (30 - FRAC_BITS));
    a = (ms * cs) / ct;
    b = -((ms * sn) / ct);
    spq = longint'(cmd.spin) * UPSCALE;
    w[0] = a + spq;
    w[1] = b + spq;
    w[2] = -a + spq;
    w[3] = -b + spq;
    m = 0;
    for (int i = 0; i < 4; i++) begin
      av = (w[i] < 0) ? -w[i] : w[i];
      if (av > m) m = av;
    end
    for (int i = 0; i < 4; i++) begin
      if (m > longint'(Q30_ONE)) v = (w[i] * (longint'(1) <<< FRAC_BITS)) / m;
      else v = w[i] / UPSCALE;
      if (v > OUT_HI) v = OUT_HI;
      if (v < OUT_LO) v = OUT_LO;
      o[i] = v[SAMPLE_BITS-1:0];
    end
    res.wheel_a = o[0];
    res.wheel_b = o[1];
    res.wheel_c = o[2];
    res.wheel_d = o[3];
  endtask

  // Hold the command until taken, then idle single cycles at random.
  task automatic send_cmd(input cmd_t cmd);
    wheels_t res;
    start <= 1'b1;
    cmd_i <= cmd;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_wheels(cmd, res);
    wheels_due.push_back(res);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_fields(input logic [15:0] mag, input logic [15:0] hd,
                             input logic [15:0] sp);
    cmd_t cmd;
    cmd.magnitude = mag;
    cmd.heading = hd;
    cmd.spin = sp;
    send_cmd(cmd);
  endtask

  // Compare each strobed result with the oldest expectation.
  always @(posedge clk_i) begin
    wheels_t exp_w;
    if (rst_ni && done_o) begin
      if (wheels_due.size() == 0) begin
        $display("%0t: unexpected result %h", $time, wheels_o);
        n_errors++;
      end else begin
        exp_w = wheels_due.pop_front();
        if (wheels_o.wheel_a !== exp_w.wheel_a) begin
          $display("%0t: wheel_a expected %0d actual %0d", $time, exp_w.wheel_a,
                   wheels_o.wheel_a);
          n_errors++;
        end
        if (wheels_o.wheel_b !== exp_w.wheel_b) begin
          $display("%0t: wheel_b expected %0d actual %0d", $time, exp_w.wheel_b,
                   wheels_o.wheel_b);
          n_errors++;
        end
        if (wheels_o.wheel_c !== exp_w.wheel_c) begin
          $display("%0t: wheel_c expected %0d actual %0d", $time, exp_w.wheel_c,
                   wheels_o.wheel_c);
          n_errors++;
        end
        if (wheels_o.wheel_d !== exp_w.wheel_d) begin
          $display("%0t: wheel_d expected %0d actual %0d", $time, exp_w.wheel_d,
                   wheels_o.wheel_d);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Extremes, octant boundaries both sides, and the exact-one saturation.
  task automatic test_directed();
    idle_pct = 0;
    send_fields(16'd32768, 16'd8192, 16'd0);
    send_fields(16'd32768, 16'd0, 16'd0);
    send_fields(16'd0, 16'd0, 16'd0);
    send_fields(16'd0, 16'd12345, 16'h8000);
    send_fields(16'd0, 16'd40000, 16'h7fff);
    send_fields(16'hffff, 16'hffff, 16'h7fff);
    send_fields(16'hffff, 16'd16384, 16'h8000);
    send_fields(16'd32768, 16'd24576, 16'h4000);
    send_fields(16'd32768, 16'd32768, 16'hc000);
    send_fields(16'd32768, 16'd40960, 16'd0);
    send_fields(16'd32768, 16'd49152, 16'd0);
    send_fields(16'd32768, 16'd57344, 16'd0);
    send_fields(16'd20000, 16'd8191, 16'd0);
    send_fields(16'd20000, 16'd8193, 16'd0);
    send_fields(16'd20000, 16'd16383, 16'd100);
    send_fields(16'd20000, 16'd1, 16'hff9c);
    send_fields(16'd16384, 16'd4096, 16'h2000);
    send_fields(16'hffff, 16'd8192, 16'd0);
    send_fields(16'd1, 16'h5555, 16'haaaa);
    send_fields(16'd32768, 16'd8192, 16'h8000);
  endtask

  task automatic send_random(input int unsigned count);
    cmd_t cmd;
    for (int unsigned k = 0; k < count; k++) begin
      cmd.heading = 16'($urandom);
      cmd.spin = 16'($urandom);
      case ($urandom_range(3))
        0: cmd.magnitude = 16'($urandom);
        1: cmd.magnitude = 16'($urandom_range(0, 32768));
        2: begin
          cmd.magnitude = 16'($urandom_range(0, 32768));
          cmd.spin = 16'($urandom_range(0, 8000) - 4000);
        end
        default: begin
          cmd.magnitude = 16'($urandom_range(0, 32768));
          cmd.heading = 16'($urandom_range(0, 7) * 8192 + $urandom_range(0, 2) - 1);
        end
      endcase
      send_cmd(cmd);
    end
  endtask

  // Back-to-back transactions with no gaps.
  task automatic test_random_burst();
    idle_pct = 0;
    send_random(250);
  endtask

  task automatic test_random_idle();
    idle_pct = 24;
    send_random(600);
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_idle();
    test_random_burst();
    start <= 1'b0;
    while (wheels_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/xdw_pkg.sv
src/xdw_octant.sv
src/x_drive_wheel_mixer_core.sv
test/x_drive_wheel_mixer_core_tb.sv
